>>> sv/ctlm_pkg.sv
// ----------------------------------------------------------------------------
// ctlm_pkg
// Shared types, codes and constants of the time-in-state load monitor.
// ----------------------------------------------------------------------------
package ctlm_pkg;

    localparam int MAX_FREQ_STATES = 16;
    localparam int FIDX_W          = $clog2(MAX_FREQ_STATES);
    localparam int RES_DEPTH       = 2 * MAX_FREQ_STATES;
    localparam int RES_AW          = $clog2(RES_DEPTH);

    localparam int TS_W    = 48;
    localparam int RES_W   = 64;
    localparam int MHZ_W   = 16;
    localparam int KHZ_W   = 24;
    localparam int NFS_W   = 5;
    localparam int PCT_W   = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_IW  = 2;

    // shared multiplier operand widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // khz to mhz: floor(x / 1000) == (x * ceil(2^34 / 1000)) >> 34 for 24-bit x
    localparam logic [MUL_B_W-1:0] KHZ_RECIP = 25'd17179870;
    localparam int                 KHZ_SHIFT = 34;

    localparam int WSUM_W = MHZ_W + RES_W + FIDX_W;
    localparam int ISUM_W = RES_W + FIDX_W;
    localparam int NUM_W  = WSUM_W + PCT_W;
    localparam int DEN_W  = 64;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    typedef enum logic [1:0] {
        CMD_FREQ  = 2'd0,
        CMD_IDLE  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_TABLE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_REJECT  = 2'd2
    } t_status;

    localparam logic [CFG_IW-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MAX_FREQ = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_NUM_FREQ = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [TS_W-1:0]  timestamp_us;
        logic [KHZ_W-1:0] freq_khz;
        logic [1:0]       idle_index;
        logic [3:0]       table_index;
        logic [MHZ_W-1:0] table_mhz;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [PCT_W-1:0] load_pct;
        logic [PCT_W-1:0] active_pct;
    } t_out_word;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_MHZ, S_MHZ_GET, S_SEARCH, S_CH_RD, S_CH_WR,
        S_RD_A, S_RD_I, S_ML, S_MH, S_MA,
        S_ST0, S_ST1, S_ST2, S_UDIV, S_UWAIT, S_BDIV, S_BWAIT,
        S_FIN, S_DONE
    } t_state;

endpackage

>>> sv/ctlm_mul.sv
// ----------------------------------------------------------------------------
// ctlm_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ctlm_mul
    import ctlm_pkg::*;
(
    input  logic               i_clk,
    input  t_mul_req           i_req,
    output logic [MUL_P_W-1:0] o_prod
);

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_req.a) * MUL_P_W'(i_req.b);
    end

    assign o_prod = r_prod;

endmodule

>>> sv/ctlm_div.sv
// ----------------------------------------------------------------------------
// ctlm_div
// Restoring divider for percent quotients, one bit per cycle, saturating
// at 100.
// ----------------------------------------------------------------------------
module ctlm_div
    import ctlm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int DSH_W = DEN_W + PCT_W - 1;

    logic             r_busy, n_busy;
    logic [2:0]       r_cnt, n_cnt;
    logic             r_sat, n_sat;
    logic [NUM_W-1:0] r_rem, n_rem;
    logic [DSH_W-1:0] r_dsh, n_dsh;
    logic [PCT_W-1:0] r_q, n_q;
    logic [NUM_W-1:0] w_top;

    // quotient of 128 or more is saturated up front
    assign w_top = NUM_W'({i_req.den, {PCT_W{1'b0}}});

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_sat  = r_sat;
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_q    = r_q;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_sat  = (i_req.num >= w_top);
            n_cnt  = n_sat ? 3'd0 : 3'(PCT_W);
            n_rem  = i_req.num;
            n_dsh  = {i_req.den, {(PCT_W-1){1'b0}}};
            n_q    = '0;
        end else if (r_busy) begin
            if (r_cnt == 3'd0) begin
                n_busy = 1'b0;
            end else begin
                if (r_rem >= NUM_W'(r_dsh)) begin
                    n_rem = r_rem - NUM_W'(r_dsh);
                    n_q   = {r_q[PCT_W-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[PCT_W-2:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat <= n_sat;
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
    end

    assign o_rsp.done = r_busy && (r_cnt == 3'd0);
    assign o_rsp.quot = (r_sat || (r_q > PCT_FULL)) ? PCT_FULL : r_q;

endmodule

>>> sv/cpu_time_in_state_load_monitor.sv
// ----------------------------------------------------------------------------
// cpu_time_in_state_load_monitor
// Per-CPU time-in-state accounting with frequency-weighted load readout.
// ----------------------------------------------------------------------------
// Usage: one input word per event (frequency change, idle change, load read,
// table write) on i_in_valid / o_in_stall; one result word per event on
// o_out_valid / i_out_stall. The config port writes enable, max_freq_mhz and
// num_freq_states by index; the user must write it only while the block is idle,
// which the block itself does not enforce. A sequencer steps one shared
// multiplier, one bit-serial divider and a one-read, one-write accumulator
// memory. Table writes, disabled events and bad idle indices go straight to
// the result; an idle change charges the current pair; a frequency change
// converts kHz to MHz, searches the n active table slots (1..16) in order
// and charges the current pair, or rejects when no slot matches; a load read
// charges, reads both accumulators of each slot, weights the non-idle one by
// its MHz, scales the elapsed time by max_freq and runs the percent divisions.
// One event is processed at a time; o_in_stall is high from acceptance until
// the result is handed to the output register. A finished result waits in
// that register while the receiver stalls, and the next event is accepted
// meanwhile. Reset clears all accumulators at once through per-entry valid
// bits, so no clearing pass is needed; the frequency table is not reset.
// ----------------------------------------------------------------------------
module cpu_time_in_state_load_monitor
    import ctlm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_data,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic             r_enable;
    logic [MHZ_W-1:0] r_max_mhz;
    logic [NFS_W-1:0] r_nfs;

    logic [MHZ_W-1:0] r_ftab [MAX_FREQ_STATES];
    logic [RES_W-1:0] r_res_mem [RES_DEPTH];
    logic [RES_W-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [RES_DEPTH-1:0] r_res_vld, n_res_vld;

    logic              mem_we;
    logic [RES_AW-1:0] mem_waddr, mem_raddr;
    logic [RES_W-1:0]  mem_wdata, rd_word;

    logic [1:0]        r_cmd, n_cmd;
    logic [TS_W-1:0]   r_ts, n_ts;
    logic [KHZ_W-1:0]  r_fkhz, n_fkhz;
    logic [1:0]        r_idx, n_idx;
    logic [MHZ_W-1:0]  r_mhz, n_mhz;
    logic [FIDX_W-1:0] r_i, n_i;
    logic [FIDX_W-1:0] r_found, n_found;
    logic [FIDX_W-1:0] r_freq_idx, n_freq_idx;
    logic              r_idle_st, n_idle_st;
    logic [TS_W-1:0]   r_last_upd, n_last_upd;
    logic [TS_W-1:0]   r_last_read, n_last_read;
    logic [WSUM_W-1:0] r_wsum, n_wsum;
    logic [ISUM_W-1:0] r_isum, n_isum;
    logic [RES_W-1:0]  r_word_a, n_word_a;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [DEN_W-1:0]  r_step, n_step;
    logic [1:0]        r_status, n_status;
    logic [PCT_W-1:0]  r_util, n_util;
    logic [PCT_W-1:0]  r_busy, n_busy;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out, n_out;

    logic [FIDX_W-1:0] last_slot;
    logic [RES_AW-1:0] cur_pos;
    logic [TS_W-1:0]   delta, elapsed, busy_time;
    logic              in_acc, tab_we;

    t_mul_req           mul_req;
    logic [MUL_P_W-1:0] mul_prod;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    ctlm_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    ctlm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc    = i_in_valid && !o_in_stall;
    assign tab_we    = in_acc && (i_in_data.command == CMD_TABLE)
                       && (int'(i_in_data.table_index) < MAX_FREQ_STATES);
    assign cur_pos   = {r_idle_st, r_freq_idx};
    assign delta     = r_ts - r_last_upd;
    assign elapsed   = r_ts - r_last_read;
    assign busy_time = elapsed - r_isum[TS_W-1:0];
    assign rd_word   = r_rd_vld ? r_rd_data : '0;

    // slot count clamped to 1..MAX_FREQ_STATES
    always_comb begin
        if (r_nfs == '0) begin
            last_slot = '0;
        end else if (int'(r_nfs) > MAX_FREQ_STATES) begin
            last_slot = FIDX_W'(MAX_FREQ_STATES - 1);
        end else begin
            last_slot = FIDX_W'(r_nfs - NFS_W'(1));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_res_vld   = r_res_vld;
        n_cmd       = r_cmd;
        n_ts        = r_ts;
        n_fkhz      = r_fkhz;
        n_idx       = r_idx;
        n_mhz       = r_mhz;
        n_i         = r_i;
        n_found     = r_found;
        n_freq_idx  = r_freq_idx;
        n_idle_st   = r_idle_st;
        n_last_upd  = r_last_upd;
        n_last_read = r_last_read;
        n_wsum      = r_wsum;
        n_isum      = r_isum;
        n_word_a    = r_word_a;
        n_num       = r_num;
        n_step      = r_step;
        n_status    = r_status;
        n_util      = r_util;
        n_busy      = r_busy;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = cur_pos;
        mem_wdata   = rd_word + RES_W'(delta);
        mem_raddr   = cur_pos;
        mul_req.a   = '0;
        mul_req.b   = '0;
        div_req     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd    = i_in_data.command;
                    n_ts     = i_in_data.timestamp_us;
                    n_fkhz   = i_in_data.freq_khz;
                    n_idx    = i_in_data.idle_index;
                    n_status = ST_DONE;
                    n_util   = '0;
                    n_busy   = '0;
                    if (i_in_data.command == CMD_TABLE) begin
                        n_state = S_DONE;
                    end else if (!r_enable) begin
                        n_status = ST_IGNORED;
                        n_state  = S_DONE;
                    end else if (i_in_data.command == CMD_FREQ) begin
                        n_state = S_MHZ;
                    end else if (i_in_data.command == CMD_IDLE) begin
                        if (i_in_data.idle_index[1]) begin
                            n_status = ST_REJECT;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_CH_RD;
                        end
                    end else begin
                        n_state = S_CH_RD;
                    end
                end
            end
            S_MHZ: begin
                mul_req.a = MUL_A_W'(r_fkhz);
                mul_req.b = KHZ_RECIP;
                n_state   = S_MHZ_GET;
            end
            S_MHZ_GET: begin
                n_mhz   = mul_prod[KHZ_SHIFT +: MHZ_W];
                n_i     = '0;
                n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (r_ftab[r_i] == r_mhz) begin
                    n_found = r_i;
                    n_state = S_CH_RD;
                end else if (r_i == last_slot) begin
                    n_status = ST_REJECT;
                    n_state  = S_DONE;
                end else begin
                    n_i = r_i + FIDX_W'(1);
                end
            end
            S_CH_RD: begin
                n_state = S_CH_WR;
            end
            S_CH_WR: begin
                // charge elapsed time to the current pair
                mem_we             = 1'b1;
                n_res_vld[cur_pos] = 1'b1;
                n_last_upd         = r_ts;
                if (r_cmd == CMD_FREQ) begin
                    n_freq_idx = r_found;
                    n_state    = S_DONE;
                end else if (r_cmd == CMD_IDLE) begin
                    n_idle_st = r_idx[0];
                    n_state   = S_DONE;
                end else begin
                    n_i     = '0;
                    n_wsum  = '0;
                    n_isum  = '0;
                    n_state = S_RD_A;
                end
            end
            S_RD_A: begin
                mem_raddr = {1'b0, r_i};
                n_state   = S_RD_I;
            end
            S_RD_I: begin
                n_word_a  = rd_word;
                mem_raddr = {1'b1, r_i};
                n_state   = S_ML;
            end
            S_ML: begin
                n_isum    = r_isum + ISUM_W'(rd_word);
                mul_req.a = r_word_a[MUL_A_W-1:0];
                mul_req.b = MUL_B_W'(r_ftab[r_i]);
                n_state   = S_MH;
            end
            S_MH: begin
                n_wsum    = r_wsum + WSUM_W'(mul_prod);
                mul_req.a = r_word_a[RES_W-1:MUL_A_W];
                mul_req.b = MUL_B_W'(r_ftab[r_i]);
                n_state   = S_MA;
            end
            S_MA: begin
                n_wsum = r_wsum + (WSUM_W'(mul_prod) << MUL_A_W);
                if (r_i == last_slot) begin
                    n_state = S_ST0;
                end else begin
                    n_i     = r_i + FIDX_W'(1);
                    n_state = S_RD_A;
                end
            end
            S_ST0: begin
                mul_req.a = elapsed[MUL_A_W-1:0];
                mul_req.b = MUL_B_W'(r_max_mhz);
                // weighted sum times 100 as 64 + 32 + 4
                n_num     = (NUM_W'(r_wsum) << 6) + (NUM_W'(r_wsum) << 5)
                            + (NUM_W'(r_wsum) << 2);
                n_state   = S_ST1;
            end
            S_ST1: begin
                n_step    = DEN_W'(mul_prod);
                mul_req.a = MUL_A_W'(elapsed[TS_W-1:MUL_A_W]);
                mul_req.b = MUL_B_W'(r_max_mhz);
                n_state   = S_ST2;
            end
            S_ST2: begin
                n_step  = r_step + (DEN_W'(mul_prod) << MUL_A_W);
                n_state = S_UDIV;
            end
            S_UDIV: begin
                if (elapsed != '0 && r_max_mhz != '0) begin
                    div_req.start = 1'b1;
                    div_req.num   = r_num;
                    div_req.den   = r_step;
                    n_state       = S_UWAIT;
                end else begin
                    n_state = S_BDIV;
                end
            end
            S_UWAIT: begin
                if (div_rsp.done) begin
                    n_util  = div_rsp.quot;
                    n_state = S_BDIV;
                end
            end
            S_BDIV: begin
                if (ISUM_W'(elapsed) > r_isum) begin
                    div_req.start = 1'b1;
                    div_req.num   = (NUM_W'(busy_time) << 6)
                                    + (NUM_W'(busy_time) << 5)
                                    + (NUM_W'(busy_time) << 2);
                    div_req.den   = DEN_W'(elapsed);
                    n_state       = S_BWAIT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_BWAIT: begin
                if (div_rsp.done) begin
                    n_busy  = div_rsp.quot;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_res_vld   = '0;
                n_last_read = r_ts;
                n_last_upd  = r_ts;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = r_status;
                    n_out.load_pct   = r_util;
                    n_out.active_pct = r_busy;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b0;
            r_max_mhz   <= '0;
            r_nfs       <= NFS_W'(1);
            r_res_vld   <= '0;
            r_rd_vld    <= 1'b0;
            r_freq_idx  <= '0;
            r_idle_st   <= 1'b0;
            r_last_upd  <= '0;
            r_last_read <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_vld   <= n_res_vld;
            r_rd_vld    <= r_res_vld[mem_raddr];
            r_freq_idx  <= n_freq_idx;
            r_idle_st   <= n_idle_st;
            r_last_upd  <= n_last_upd;
            r_last_read <= n_last_read;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENABLE:   r_enable  <= i_cfg_data[0];
                    CFG_MAX_FREQ: r_max_mhz <= i_cfg_data[MHZ_W-1:0];
                    CFG_NUM_FREQ: r_nfs     <= i_cfg_data[NFS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_ts     <= n_ts;
        r_fkhz   <= n_fkhz;
        r_idx    <= n_idx;
        r_mhz    <= n_mhz;
        r_i      <= n_i;
        r_found  <= n_found;
        r_wsum   <= n_wsum;
        r_isum   <= n_isum;
        r_word_a <= n_word_a;
        r_num    <= n_num;
        r_step   <= n_step;
        r_status <= n_status;
        r_util   <= n_util;
        r_busy   <= n_busy;
        r_out    <= n_out;
        if (tab_we) begin
            r_ftab[i_in_data.table_index[FIDX_W-1:0]] <= i_in_data.table_mhz;
        end
    end

    // accumulator memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_res_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_res_mem[mem_raddr];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/ctlm_chk.sv
// ----------------------------------------------------------------------------
// ctlm_chk
// Port-level checks of the load monitor, bound to the top level.
// ----------------------------------------------------------------------------
module ctlm_chk
    import ctlm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_word         o_out_data
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one word at a time
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while busy");

    a_zero_figs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_DONE)
        |-> (o_out_data.load_pct == '0) && (o_out_data.active_pct == '0))
        else $error("figures on a non-done result");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.load_pct <= PCT_FULL)
                        && (o_out_data.active_pct <= PCT_FULL)
                        && (o_out_data.status != 2'd3))
        else $error("result out of range");

endmodule

bind cpu_time_in_state_load_monitor ctlm_chk u_ctlm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> test/load_monitor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// load_monitor_checker
// Watches the config port and both word channels of the load monitor, keeps
// its own copy of the residency accounting, predicts each result word and
// compares it field by field with the word the block hands out.
// ----------------------------------------------------------------------------
module load_monitor_checker
    import ctlm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_word          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_word         i_out_data,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_pending,
    output int                o_fail_count
);

    logic                   enable_q;
    logic [MHZ_W-1:0]       max_mhz_q;
    logic [NFS_W-1:0]       nfs_q;
    logic [RES_W-1:0]       residency [RES_DEPTH];
    logic [MHZ_W-1:0]       mhz_table [MAX_FREQ_STATES];
    logic [TS_W-1:0]        upd_mark;
    logic [TS_W-1:0]        read_mark;
    logic [FIDX_W-1:0]      cur_slot;
    logic                   cur_idle;
    t_out_word              expected_words [$];
    int                     fails;

    assign o_pending    = expected_words.size();
    assign o_fail_count = fails;

    function automatic int active_slots();
        if (nfs_q == 0)
            return 1;
        if (nfs_q > MAX_FREQ_STATES)
            return MAX_FREQ_STATES;
        return int'(nfs_q);
    endfunction

    function automatic void charge_time(logic [TS_W-1:0] now);
        logic [TS_W-1:0] delta;
        delta = now - upd_mark;
        residency[{cur_idle, cur_slot}] += RES_W'(delta);
        upd_mark = now;
    endfunction

    // one event through the accounting, returns the result word it yields
    function automatic t_out_word account_event(t_in_word w);
        t_out_word        r;
        logic [KHZ_W-1:0] mhz;
        logic [127:0]     weighted, idle_sum, num, step, q;
        logic [TS_W-1:0]  elapsed;
        logic [63:0]      busy;
        int               n, found;
        r = '0;
        n = active_slots();
        if (w.command == CMD_TABLE) begin
            mhz_table[w.table_index] = w.table_mhz;
            r.status = ST_DONE;
        end else if (!enable_q) begin
            r.status = ST_IGNORED;
        end else if (w.command == CMD_FREQ) begin
            mhz = KHZ_W'(w.freq_khz / 1000);
            found = -1;
            for (int i = 0; i < n; i++)
                if (found < 0 && KHZ_W'(mhz_table[i]) == mhz)
                    found = i;
            if (found < 0) begin
                r.status = ST_REJECT;
            end else begin
                charge_time(w.timestamp_us);
                cur_slot = FIDX_W'(found);
                r.status = ST_DONE;
            end
        end else if (w.command == CMD_IDLE) begin
            if (w.idle_index >= 2) begin
                r.status = ST_REJECT;
            end else begin
                charge_time(w.timestamp_us);
                cur_idle = w.idle_index[0];
                r.status = ST_DONE;
            end
        end else begin
            charge_time(w.timestamp_us);
            elapsed  = w.timestamp_us - read_mark;
            weighted = '0;
            idle_sum = '0;
            for (int i = 0; i < n; i++) begin
                weighted += 128'(mhz_table[i]) * 128'(residency[i]);
                idle_sum += 128'(residency[MAX_FREQ_STATES + i]);
            end
            if (elapsed != 0 && max_mhz_q != 0) begin
                num  = weighted * 128'd100;
                step = 128'(elapsed) * 128'(max_mhz_q);
                q    = num / step;
                r.load_pct = (q > 100) ? PCT_FULL : PCT_W'(q);
            end
            if (idle_sum[127:64] == 0 && 64'(elapsed) > idle_sum[63:0]) begin
                busy = (64'd100 * (64'(elapsed) - idle_sum[63:0])) / 64'(elapsed);
                r.active_pct = PCT_W'(busy);
            end
            for (int i = 0; i < RES_DEPTH; i++)
                residency[i] = '0;
            read_mark = w.timestamp_us;
            upd_mark  = w.timestamp_us;
            r.status = ST_DONE;
        end
        return r;
    endfunction

    initial fails = 0;

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            enable_q    = 1'b0;
            max_mhz_q   = '0;
            nfs_q       = NFS_W'(1);
            upd_mark    = '0;
            read_mark   = '0;
            cur_slot    = '0;
            cur_idle    = 1'b0;
            for (int i = 0; i < RES_DEPTH; i++)
                residency[i] = '0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ENABLE:   enable_q  = i_cfg_data[0];
                    CFG_MAX_FREQ: max_mhz_q = i_cfg_data[MHZ_W-1:0];
                    CFG_NUM_FREQ: nfs_q     = i_cfg_data[NFS_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result word %h", i_out_data);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w !== i_out_data) begin
                        fails++;
                        if (fails <= 10)
                            $display("result mismatch: status %0d/%0d load %0d/%0d active %0d/%0d",
                                     exp_w.status, i_out_data.status,
                                     exp_w.load_pct, i_out_data.load_pct,
                                     exp_w.active_pct, i_out_data.active_pct);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(account_event(i_in_data));
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives events, table loads and config phases into the load monitor with
// random gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import ctlm_pkg::*;

    localparam int LIMIT = 20000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_word          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_word         o_out_data;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    int                pending;
    int                fail_count;
    int                quiet_cycles;
    int                stall_hold;
    bit                quiet;
    logic [TS_W-1:0]   now_us;
    logic [MHZ_W-1:0]  table_copy [MAX_FREQ_STATES];
    int                slots_used;

    cpu_time_in_state_load_monitor i_dut (.*);

    load_monitor_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver stalls: mostly short bursts, a few long ones
    always @(negedge i_clk) begin
        int r;
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (!quiet && r < 30) begin
                i_out_stall <= 1'b1;
                stall_hold  <= (r < 26) ? $urandom_range(1, 4) : $urandom_range(20, 80);
            end else begin
                i_out_stall <= 1'b0;
                stall_hold  <= $urandom_range(1, 15);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(t_in_word w);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = quiet ? 0 : (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = w;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_NUM_FREQ)
            slots_used = (val[NFS_W-1:0] == 0) ? 1 :
                         (val[NFS_W-1:0] > MAX_FREQ_STATES) ? MAX_FREQ_STATES
                                                             : int'(val[NFS_W-1:0]);
    endtask

    function automatic t_in_word noise_word(t_cmd c);
        t_in_word w;
        w = {$urandom, $urandom, $urandom};
        w.command = c;
        w.timestamp_us = now_us;
        return w;
    endfunction

    function automatic t_in_word table_word(int slot, logic [MHZ_W-1:0] mhz);
        t_in_word w;
        w = noise_word(CMD_TABLE);
        w.table_index = slot[3:0];
        w.table_mhz   = mhz;
        table_copy[slot] = mhz;
        return w;
    endfunction

    function automatic t_in_word freq_word(int slot, int rem);
        t_in_word w;
        w = noise_word(CMD_FREQ);
        w.freq_khz = KHZ_W'(KHZ_W'(table_copy[slot]) * 1000 + KHZ_W'(rem));
        return w;
    endfunction

    function automatic t_in_word idle_word(logic [1:0] idx);
        t_in_word w;
        w = noise_word(CMD_IDLE);
        w.idle_index = idx;
        return w;
    endfunction

    function automatic void advance_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            now_us += TS_W'($urandom_range(0, 2000));
        else if (r < 97)
            now_us += TS_W'({$urandom, $urandom} & 64'h0000_0000_FFFF_FFFF);
        else
            now_us = TS_W'({$urandom, $urandom});
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int r;
        advance_time();
        r = $urandom_range(0, 99);
        if (r < 33) begin
            w = freq_word($urandom_range(0, slots_used - 1), $urandom_range(0, 999));
        end else if (r < 38) begin
            w = noise_word(CMD_FREQ);
        end else if (r < 62) begin
            w = idle_word(($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                                        : 2'($urandom_range(0, 1)));
        end else if (r < 85) begin
            w = noise_word(CMD_READ);
        end else begin
            w = table_word($urandom_range(0, MAX_FREQ_STATES - 1),
                           ($urandom_range(0, 4) == 0) ? MHZ_W'($urandom)
                                                       : MHZ_W'($urandom_range(0, 16777)));
        end
        return w;
    endfunction

    initial begin
        t_in_word w;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        stall_hold  = 0;
        quiet_cycles = 0;
        quiet       = 1'b0;
        slots_used  = 1;
        now_us      = 48'd100;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // disabled: events ignored, table loads still land
        send_word(noise_word(CMD_FREQ));
        send_word(idle_word(2'd1));
        send_word(noise_word(CMD_READ));
        for (int i = 0; i < MAX_FREQ_STATES; i++)
            send_word(table_word(i, (i == 15) ? 16'd16777 : (i == 14) ? 16'hFFFF
                                               : MHZ_W'(100 * (i + 1))));
        drain();
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_MAX_FREQ, 16'hFFFF);
        write_reg(CFG_NUM_FREQ, 16'd16);

        now_us += 500;
        send_word(freq_word(15, 999));
        send_word(idle_word(2'd2));
        send_word(idle_word(2'd3));
        now_us += 300;
        send_word(idle_word(2'd1));
        send_word(noise_word(CMD_READ));
        send_word(noise_word(CMD_READ));           // zero elapsed time
        now_us = 48'hFFFF_FFFF_FF00;
        send_word(freq_word(0, 0));
        w = noise_word(CMD_FREQ);
        w.freq_khz = 24'hFFFFFF;                   // top kHz code, in the table as 16777 MHz
        send_word(w);
        now_us = 48'd50;                           // time wraps around
        send_word(noise_word(CMD_READ));

        for (int phase = 0; phase < 8; phase++) begin
            drain();
            case (phase)
                0: begin write_reg(CFG_MAX_FREQ, 16'($urandom_range(1, 20000)));
                         write_reg(CFG_NUM_FREQ, 16'($urandom_range(1, 16))); end
                1: write_reg(CFG_MAX_FREQ, 16'd0);
                2: begin write_reg(CFG_MAX_FREQ, 16'd1); write_reg(CFG_NUM_FREQ, 16'd0); end
                3: begin write_reg(CFG_MAX_FREQ, 16'd3000); write_reg(CFG_NUM_FREQ, 16'd31); end
                4: write_reg(CFG_ENABLE, 16'd0);
                5: begin write_reg(CFG_ENABLE, 16'hFFFF); write_reg(CFG_NUM_FREQ, 16'd16);
                         write_reg(CFG_MAX_FREQ, 16'hFFFF); end
                6: begin write_reg(CFG_NUM_FREQ, 16'd1); write_reg(CFG_MAX_FREQ, 16'd100); end
                default: begin write_reg(CFG_NUM_FREQ, 16'd8); write_reg(CFG_MAX_FREQ, 16'd1500); end
            endcase
            quiet = (phase == 6);
            for (int k = 0; k < 135; k++) begin
                if (k == 70 && phase == 2) begin
                    i_in_valid = 1'b0;
                    while (pending != 0)
                        @(negedge i_clk);
                end
                send_word(random_word());
            end
            quiet = 1'b0;
        end

        i_in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> cpu_time_in_state_load_monitor.f
sv/ctlm_pkg.sv
sv/ctlm_mul.sv
sv/ctlm_div.sv
sv/cpu_time_in_state_load_monitor.sv
sv/ctlm_chk.sv
test/load_monitor_checker.sv
test/testbench.sv
